// ===== rtl/core/vadp_pkg.sv =====
package vadp_pkg;

    localparam int VALUE_W     = 31;
    localparam int STATUS_W    = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_AD     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SAMPLE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_VALUE = 2'd3;

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_D     = 8'h44;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [3:0] {
        CLS_OTHER,
        CLS_NEWLINE,
        CLS_TAB,
        CLS_COLON,
        CLS_COMMA,
        CLS_DIGIT,
        CLS_HASH,
        CLS_LETTER_A,
        CLS_LETTER_D
    } byte_class_t;

    typedef struct packed {
        byte_class_t cls;
        logic [3:0]  digit;
    } byte_item_t;

endpackage

// ===== rtl/core/vadp_front.sv =====
module vadp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 text_valid,
    output logic                 text_stall,
    input  logic [7:0]           text_byte,
    output logic                 push,
    output vadp_pkg::byte_item_t push_item,
    input  logic                 push_ready
);

    logic                 valid_reg;
    logic                 valid_next;
    vadp_pkg::byte_item_t item_reg;
    vadp_pkg::byte_item_t item_next;
    vadp_pkg::byte_item_t classified;
    logic                 accept;

    always_comb
    begin
        classified.digit = text_byte[3:0];  // low nibble of '0'..'9' is the digit
        if (text_byte == vadp_pkg::CHAR_NL)
            classified.cls = vadp_pkg::CLS_NEWLINE;
        else if (text_byte == vadp_pkg::CHAR_TAB)
            classified.cls = vadp_pkg::CLS_TAB;
        else if (text_byte == vadp_pkg::CHAR_COLON)
            classified.cls = vadp_pkg::CLS_COLON;
        else if (text_byte == vadp_pkg::CHAR_COMMA)
            classified.cls = vadp_pkg::CLS_COMMA;
        else if (text_byte >= vadp_pkg::CHAR_ZERO && text_byte <= vadp_pkg::CHAR_NINE)
            classified.cls = vadp_pkg::CLS_DIGIT;
        else if (text_byte == vadp_pkg::CHAR_HASH)
            classified.cls = vadp_pkg::CLS_HASH;
        else if (text_byte == vadp_pkg::CHAR_A)
            classified.cls = vadp_pkg::CLS_LETTER_A;
        else if (text_byte == vadp_pkg::CHAR_D)
            classified.cls = vadp_pkg::CLS_LETTER_D;
        else
            classified.cls = vadp_pkg::CLS_OTHER;
    end

    assign text_stall = valid_reg && !push_ready;
    assign accept     = text_valid && !text_stall;
    assign push       = valid_reg && push_ready;
    assign push_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            item_next  = classified;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            item_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            item_reg  <= item_next;
        end
    end

endmodule

// ===== rtl/core/vadp_fifo.sv =====
module vadp_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  vadp_pkg::byte_item_t push_item,
    output logic                 push_ready,
    output logic                 head_valid,
    output vadp_pkg::byte_item_t head_item,
    input  logic                 pop
);

    localparam int DEPTH = vadp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    vadp_pkg::byte_item_t slots_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_item  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_item;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_ready || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

// ===== rtl/core/vadp_back.sv =====
module vadp_back #(
    parameter int MAX_SUBFIELDS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  vadp_pkg::byte_item_t          head_item,
    output logic                          pop,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [vadp_pkg::VALUE_W-1:0]  position,
    output logic [vadp_pkg::VALUE_W-1:0]  ref_depth,
    output logic [vadp_pkg::VALUE_W-1:0]  alt_depth,
    output logic [vadp_pkg::STATUS_W-1:0] status
);

    localparam int VW    = vadp_pkg::VALUE_W;
    localparam int SUB_W = $clog2(MAX_SUBFIELDS + 1);

    localparam logic [3:0] COL_POS    = 4'd1;
    localparam logic [3:0] COL_FORMAT = 4'd8;
    localparam logic [3:0] COL_SAMPLE = 4'd9;
    localparam logic [3:0] COL_LAST   = 4'd10;

    localparam logic [VW-1:0] SAT_MAX = {VW{1'b1}};

    typedef enum logic [1:0] {LM_START, LM_DATA, LM_COMMENT} line_mode_t;
    typedef enum logic [1:0] {TOK_START, TOK_A, TOK_AD, TOK_NONE} token_t;
    typedef enum logic [1:0] {PH_PRE_REF, PH_REF, PH_COMMA, PH_ALT} phase_t;

    function automatic logic [VW-1:0] add_digit(input logic [VW-1:0] acc,
                                                input logic [3:0] d);
        logic [VW+3:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{VW{1'b0}}, d};
        return (v > {4'b0000, SAT_MAX}) ? SAT_MAX : v[VW-1:0];
    endfunction

    line_mode_t        mode_reg,   mode_next, mode_eff;
    logic [3:0]        col_reg,    col_next;
    logic [SUB_W-1:0]  sub_reg,    sub_next;
    token_t            tok_reg,    tok_next;
    logic [SUB_W-1:0]  slot_reg,   slot_next;
    logic              found_reg,  found_next;
    logic [VW-1:0]     pos_reg,    pos_next;
    logic [VW-1:0]     ref_reg,    ref_next;
    logic [VW-1:0]     alt_reg,    alt_next;
    phase_t            phase_reg,  phase_next;
    logic              bad_reg,    bad_next;
    logic              closed_reg, closed_next;

    logic                          out_valid_reg, out_valid_next;
    logic [VW-1:0]                 out_pos_reg,   out_pos_next;
    logic [VW-1:0]                 out_ref_reg,   out_ref_next;
    logic [VW-1:0]                 out_alt_reg,   out_alt_next;
    logic [vadp_pkg::STATUS_W-1:0] out_st_reg,    out_st_next;

    vadp_pkg::byte_class_t cls;
    logic                  is_nl;
    logic                  emit;
    logic                  format_hit;
    logic                  found_eff;
    logic                  in_slot;
    logic                  ref_side;
    logic [VW-1:0]         acc_sel;
    logic [VW-1:0]         acc_sum;
    logic [SUB_W-1:0]      sub_inc;
    logic [vadp_pkg::STATUS_W-1:0] line_status;

    assign cls   = head_item.cls;
    assign is_nl = cls == vadp_pkg::CLS_NEWLINE;
    assign emit  = head_valid && is_nl && mode_reg == LM_DATA;
    // only a line end that produces a beat waits on the output register
    assign pop   = head_valid && (!emit || !out_valid_reg || !result_stall);

    assign format_hit = tok_reg == TOK_AD && !found_reg && sub_reg < SUB_W'(MAX_SUBFIELDS);
    assign found_eff  = found_reg || (col_reg == COL_FORMAT && format_hit);
    assign sub_inc    = (sub_reg < SUB_W'(MAX_SUBFIELDS)) ? sub_reg + 1'b1 : sub_reg;
    assign in_slot    = found_reg && sub_reg == slot_reg && !closed_reg && !bad_reg;
    assign ref_side   = phase_reg == PH_PRE_REF || phase_reg == PH_REF;

    // one shared multiply-by-ten unit; only one number grows per byte
    assign acc_sel = (col_reg == COL_POS) ? pos_reg : (ref_side ? ref_reg : alt_reg);
    assign acc_sum = add_digit(acc_sel, head_item.digit);

    always_comb
    begin
        if (!found_eff)
            line_status = vadp_pkg::ST_NO_AD;
        else if (col_reg < COL_SAMPLE)
            line_status = vadp_pkg::ST_NO_SAMPLE;
        else if (bad_reg || phase_reg != PH_ALT)
            line_status = vadp_pkg::ST_BAD_VALUE;
        else
            line_status = vadp_pkg::ST_OK;
    end

    always_comb
    begin
        mode_eff = mode_reg;
        if (mode_reg == LM_START)
            mode_eff = (cls == vadp_pkg::CLS_HASH) ? LM_COMMENT : LM_DATA;
    end

    always_comb
    begin
        mode_next   = mode_reg;
        col_next    = col_reg;
        sub_next    = sub_reg;
        tok_next    = tok_reg;
        slot_next   = slot_reg;
        found_next  = found_reg;
        pos_next    = pos_reg;
        ref_next    = ref_reg;
        alt_next    = alt_reg;
        phase_next  = phase_reg;
        bad_next    = bad_reg;
        closed_next = closed_reg;

        out_valid_next = out_valid_reg && result_stall;
        out_pos_next   = out_pos_reg;
        out_ref_next   = out_ref_reg;
        out_alt_next   = out_alt_reg;
        out_st_next    = out_st_reg;

        if (pop)
        begin
            if (is_nl)
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = pos_reg;
                    out_st_next    = line_status;
                    out_ref_next   = (line_status == vadp_pkg::ST_OK) ? ref_reg : '0;
                    out_alt_next   = (line_status == vadp_pkg::ST_OK) ? alt_reg : '0;
                end
                mode_next   = LM_START;
                col_next    = '0;
                sub_next    = '0;
                tok_next    = TOK_START;
                slot_next   = '0;
                found_next  = 1'b0;
                pos_next    = '0;
                ref_next    = '0;
                alt_next    = '0;
                phase_next  = PH_PRE_REF;
                bad_next    = 1'b0;
                closed_next = 1'b0;
            end
            else
            begin
                mode_next = mode_eff;
                if (mode_eff == LM_DATA)
                begin
                    if (cls == vadp_pkg::CLS_TAB)
                    begin
                        if (col_reg == COL_FORMAT && format_hit)
                        begin
                            found_next = 1'b1;
                            slot_next  = sub_reg;
                        end
                        if (col_reg < COL_LAST)
                            col_next = col_reg + 1'b1;
                        sub_next = '0;
                        tok_next = TOK_START;
                    end
                    else if (col_reg == COL_POS)
                    begin
                        if (cls == vadp_pkg::CLS_DIGIT)
                            pos_next = acc_sum;
                    end
                    else if (col_reg == COL_FORMAT)
                    begin
                        case (cls)
                            vadp_pkg::CLS_COLON:
                            begin
                                if (format_hit)
                                begin
                                    found_next = 1'b1;
                                    slot_next  = sub_reg;
                                end
                                sub_next = sub_inc;
                                tok_next = TOK_START;
                            end
                            vadp_pkg::CLS_LETTER_A:
                                tok_next = (tok_reg == TOK_START) ? TOK_A : TOK_NONE;
                            vadp_pkg::CLS_LETTER_D:
                                tok_next = (tok_reg == TOK_A) ? TOK_AD : TOK_NONE;
                            default:
                                tok_next = TOK_NONE;
                        endcase
                    end
                    else if (col_reg == COL_SAMPLE)
                    begin
                        if (cls == vadp_pkg::CLS_COLON)
                            sub_next = sub_inc;
                        else if (in_slot)
                        begin
                            case (cls)
                                vadp_pkg::CLS_DIGIT:
                                begin
                                    if (ref_side)
                                    begin
                                        ref_next   = acc_sum;
                                        phase_next = PH_REF;
                                    end
                                    else
                                    begin
                                        alt_next   = acc_sum;
                                        phase_next = PH_ALT;
                                    end
                                end
                                vadp_pkg::CLS_COMMA:
                                begin
                                    if (phase_reg == PH_REF)
                                        phase_next = PH_COMMA;
                                    else if (phase_reg == PH_ALT)
                                        closed_next = 1'b1;  // extra alleles follow
                                    else
                                        bad_next = 1'b1;
                                end
                                default:
                                    bad_next = 1'b1;
                            endcase
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= LM_START;
            col_reg       <= '0;
            sub_reg       <= '0;
            tok_reg       <= TOK_START;
            slot_reg      <= '0;
            found_reg     <= 1'b0;
            pos_reg       <= '0;
            ref_reg       <= '0;
            alt_reg       <= '0;
            phase_reg     <= PH_PRE_REF;
            bad_reg       <= 1'b0;
            closed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_pos_reg   <= '0;
            out_ref_reg   <= '0;
            out_alt_reg   <= '0;
            out_st_reg    <= vadp_pkg::ST_OK;
        end
        else
        begin
            mode_reg      <= mode_next;
            col_reg       <= col_next;
            sub_reg       <= sub_next;
            tok_reg       <= tok_next;
            slot_reg      <= slot_next;
            found_reg     <= found_next;
            pos_reg       <= pos_next;
            ref_reg       <= ref_next;
            alt_reg       <= alt_next;
            phase_reg     <= phase_next;
            bad_reg       <= bad_next;
            closed_reg    <= closed_next;
            out_valid_reg <= out_valid_next;
            out_pos_reg   <= out_pos_next;
            out_ref_reg   <= out_ref_next;
            out_alt_reg   <= out_alt_next;
            out_st_reg    <= out_st_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign position     = out_pos_reg;
    assign ref_depth    = out_ref_reg;
    assign alt_depth    = out_alt_reg;
    assign status       = out_st_reg;

    a_depths_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_st_reg != vadp_pkg::ST_OK)
            |-> (out_ref_reg == '0 && out_alt_reg == '0))
        else $error("depths reported on a failed line");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> slot_reg < SUB_W'(MAX_SUBFIELDS))
        else $error("AD slot beyond subfield limit");

    a_counters_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_LAST && sub_reg <= SUB_W'(MAX_SUBFIELDS))
        else $error("column or subfield count past saturation");

    a_emit_loads_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && emit) |=> out_valid_reg)
        else $error("data line end gave no beat");

    a_values_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != LM_DATA) |-> (pos_reg == '0 && !found_reg && col_reg == '0))
        else $error("line state changed outside a data line");

endmodule

// ===== rtl/core/vcf_allele_depth_parser.sv =====
// Path: a newline beat passes through the front register and the queue, and the state update
// then loads its result into the output register.
// Throughput: one text byte per cycle unless text_stall is high; a line end waits only while
// the output register is full and stalled, and the four-entry queue absorbs that.
// Reset: rst_n clears all line state, the queue and the output register at once.
module vcf_allele_depth_parser #(
    parameter int MAX_SUBFIELDS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          text_valid,
    output logic                          text_stall,
    input  logic [7:0]                    text_byte,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [vadp_pkg::VALUE_W-1:0]  position,
    output logic [vadp_pkg::VALUE_W-1:0]  ref_depth,
    output logic [vadp_pkg::VALUE_W-1:0]  alt_depth,
    output logic [vadp_pkg::STATUS_W-1:0] status
);

    logic                 push;
    logic                 push_ready;
    vadp_pkg::byte_item_t push_item;
    logic                 head_valid;
    vadp_pkg::byte_item_t head_item;
    logic                 pop;

    vadp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_byte  (text_byte),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    vadp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    vadp_back #(
        .MAX_SUBFIELDS (MAX_SUBFIELDS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .position     (position),
        .ref_depth    (ref_depth),
        .alt_depth    (alt_depth),
        .status       (status)
    );

endmodule
